// ===== hw/rtl/dtl_pkg.sv =====
// Shared types and constants for the text layout / glyph address block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package dtl_pkg;

  // Screen geometry, in pixels
  localparam logic [9:0] SCREEN_WIDTH  = 10'd320;
  localparam logic [9:0] SCREEN_HEIGHT = 10'd240;

  localparam logic [9:0] GLYPH_NARROW = 10'd8;
  localparam logic [9:0] GLYPH_WIDE   = 10'd16;
  localparam logic [9:0] LINE_PITCH   = 10'd16;
  localparam logic [9:0] MONO_ASCII_DY = 10'd2;

  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_WIDE_SP = 8'hA1;  // both bytes of the full-width space

  localparam logic       CMD_BEGIN = 1'b0;
  localparam logic       CMD_BYTE  = 1'b1;

  typedef enum logic [1:0] {
    FONT_GRAY_GB    = 2'd0,
    FONT_MONO_GB    = 2'd1,
    FONT_GRAY_OTHER = 2'd2,
    FONT_MONO_GBK   = 2'd3
  } font_kind_e;

  typedef enum logic [2:0] {
    KIND_ASCII_GRAY = 3'd0,
    KIND_ASCII_MONO = 3'd1,
    KIND_HANZI_GRAY = 3'd2,
    KIND_HANZI_MONO = 3'd3,
    KIND_FINISHED   = 3'd4,
    KIND_BAD_CODE   = 3'd5
  } kind_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] code_byte;
    logic [8:0] start_x;
    logic [8:0] start_y;
    logic [3:0] fg_color;
    logic [3:0] bg_color;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [9:0]  draw_x;
    logic [9:0]  draw_y;
    logic [6:0]  ascii_code;
    logic [20:0] glyph_offset;
    logic        invert;
    logic [3:0]  out_fg;
    logic [3:0]  out_bg;
  } out_beat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dtl_in_if.sv =====
// Input channel: valid/ready handshake carrying one string beat.
// Depends on dtl_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dtl_in_if;
  import dtl_pkg::*;

  logic     valid;
  logic     ready;
  in_beat_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dtl_out_if.sv =====
// Output channel: valid/ready handshake carrying one draw command beat.
// Depends on dtl_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dtl_out_if;
  import dtl_pkg::*;

  logic      valid;
  logic      ready;
  out_beat_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dbcs_text_layout_glyph_address.sv =====
// Top level of the mixed single/double-byte text layout block.
// Depends on dtl_pkg, dtl_in_if, dtl_out_if and dtl_layout.
//
// Usage:
//   in_ch  - sink of string beats. A beat with cmd = begin loads the cursor
//            and colors; a beat with cmd = byte carries one string byte.
//   out_ch - source of draw command beats (ascii / hanzi glyph, finished,
//            bad code). A byte gives at most one command; many give none.
//   cfg_we_i / cfg_wdata_i - write the 2-bit font kind; write only while
//            the block is idle.
// Path: an accepted beat is registered in the input register, worked through
//   the layout logic, and its command is loaded into the output register,
//   from which it is offered on out_ch.
// Throughput: one beat per cycle while out_ch does not stall; the cursor
//   update and the offset multiply fit between the input and output registers.
// Reset: the cursor, colors and lead byte clear, font kind returns to gray
//   GB2312, and the block is stopped: bytes are ignored until a begin beat.
// Stall: while out_ch holds a command that is not taken, the input register
//   still takes one more beat; after that in_ch.ready drops until out_ch
//   drains. No beat is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module dbcs_text_layout_glyph_address (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_wdata_i,
  dtl_in_if.sink       in_ch,
  dtl_out_if.source    out_ch
);
  import dtl_pkg::*;

  // input register
  logic      s1_valid_q;
  in_beat_t  s1_item_q;
  logic      s1_adv;

  // layout result
  logic      res_valid;
  out_beat_t res;

  // output register
  logic      out_valid_q;
  out_beat_t out_beat_q;

  // the staged beat moves on whenever the output register is free or draining
  assign s1_adv      = s1_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item_q <= in_ch.payload;
    end
  end

  dtl_layout u_layout (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .step_i     (s1_adv),
    .item_i     (s1_item_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= res_valid;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && res_valid) begin
      out_beat_q <= res;
    end
  end

  assign out_ch.valid   = out_valid_q;
  assign out_ch.payload = out_beat_q;

endmodule

`default_nettype wire

// ===== hw/rtl/dtl_glyph_addr.sv =====
// Glyph file offset for a double-byte code under the selected font.
// Depends on dtl_pkg. Pure combinational: one multiply by the row length (94 or 190).
`timescale 1ns / 1ps
`default_nettype none

module dtl_glyph_addr (
  input  dtl_pkg::font_kind_e font_i,
  input  logic [7:0]          lead_i,
  input  logic [7:0]          trail_i,
  output logic [20:0]         offset_o,
  output logic                neg_o
);
  import dtl_pkg::*;

  logic signed [8:0]  row;
  logic signed [8:0]  col;
  logic signed [8:0]  row_len;
  logic signed [17:0] prod;
  logic signed [17:0] idx;

  // row/col relative to the first code of the table
  always_comb begin
    row_len = 9'sd94;
    row     = $signed({1'b0, lead_i}) - 9'sd160;
    col     = $signed({1'b0, trail_i}) - 9'sd160;
    case (font_i)
      FONT_MONO_GB: begin
        row = $signed({1'b0, lead_i}) - 9'sd161;
        col = $signed({1'b0, trail_i}) - 9'sd161;
      end
      FONT_MONO_GBK: begin
        row_len = 9'sd190;
        row     = $signed({1'b0, lead_i}) - 9'sd129;
        // GBK trail bytes skip 0x7F
        col     = (trail_i < 8'h7F) ? $signed({1'b0, trail_i}) - 9'sd64
                                    : $signed({1'b0, trail_i}) - 9'sd65;
      end
      default: begin
      end
    endcase
  end

  assign prod  = row_len * row;
  assign idx   = prod + 18'(col);
  assign neg_o = idx[17];

  // 16x16 gray glyphs are 128 bytes, mono glyphs 32 bytes
  always_comb begin
    if (neg_o) begin
      offset_o = '0;
    end else if (font_i == FONT_GRAY_GB) begin
      offset_o = {idx[13:0], 7'd0};
    end else begin
      offset_o = {idx[15:0], 5'd0};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dtl_layout.sv =====
// Text cursor, lead byte pairing and draw command generation for one beat.
// Depends on dtl_pkg and dtl_glyph_addr. State advances when step_i is high.
`timescale 1ns / 1ps
`default_nettype none

module dtl_layout (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_wdata_i,
  input  logic               step_i,
  input  dtl_pkg::in_beat_t  item_i,
  output logic               res_valid_o,
  output dtl_pkg::out_beat_t res_o
);
  import dtl_pkg::*;

  font_kind_e font_q;
  logic [9:0] cursor_x_q, cursor_x_d;
  logic [9:0] cursor_y_q, cursor_y_d;
  logic [7:0] lead_q, lead_d;
  logic       lead_pend_q, lead_pend_d;
  logic       drop_q, drop_d;
  logic       stopped_q, stopped_d;
  logic [3:0] fg_q, fg_d;
  logic [3:0] bg_q, bg_d;

  logic [9:0]  x1, y1, x2, y2;
  logic        inv;
  logic        wrap_lead;
  logic [20:0] offset;
  logic        neg;
  logic [7:0]  b;

  assign b   = item_i.code_byte;
  assign inv = (fg_q == 4'd15) && (bg_q == 4'd0);

  dtl_glyph_addr u_addr (
    .font_i  (font_q),
    .lead_i  (lead_q),
    .trail_i (b),
    .offset_o(offset),
    .neg_o   (neg)
  );

  // Line wrap chain: past the right edge, then glyph fit
  always_comb begin
    x1 = cursor_x_q;
    y1 = cursor_y_q;
    if (cursor_x_q > SCREEN_WIDTH) begin
      x1 = '0;
      y1 = cursor_y_q + LINE_PITCH;
    end
    x2 = x1;
    y2 = y1;
    if (x1 > SCREEN_WIDTH - GLYPH_NARROW) begin
      x2 = '0;
      y2 = y1 + LINE_PITCH;
    end
    wrap_lead = ({1'b0, x1} + 11'(GLYPH_NARROW)) >= {1'b0, SCREEN_WIDTH};
  end

  always_comb begin
    cursor_x_d  = cursor_x_q;
    cursor_y_d  = cursor_y_q;
    lead_d      = lead_q;
    lead_pend_d = lead_pend_q;
    drop_d      = drop_q;
    stopped_d   = stopped_q;
    fg_d        = fg_q;
    bg_d        = bg_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (item_i.cmd == CMD_BEGIN) begin
      cursor_x_d  = {1'b0, item_i.start_x};
      cursor_y_d  = {1'b0, item_i.start_y};
      fg_d        = item_i.fg_color;
      bg_d        = item_i.bg_color;
      stopped_d   = 1'b0;
      lead_pend_d = 1'b0;
      lead_d      = '0;
      drop_d      = 1'b0;
    end else if (stopped_q) begin
      // idle until the next begin
    end else if (drop_q) begin
      drop_d = 1'b0;
    end else if (lead_pend_q) begin
      if (b == CHAR_NUL) begin
        stopped_d   = 1'b1;
        lead_pend_d = 1'b0;
        res_valid_o = 1'b1;
        res_o.kind  = KIND_FINISHED;
      end else begin
        lead_pend_d = 1'b0;
        cursor_x_d  = cursor_x_q + GLYPH_WIDE;
        if (!(lead_q == CHAR_WIDE_SP && b == CHAR_WIDE_SP)
            && font_q != FONT_GRAY_OTHER) begin
          res_valid_o  = 1'b1;
          res_o.draw_x = cursor_x_q;
          res_o.draw_y = cursor_y_q;
          if (neg) begin
            res_o.kind = KIND_BAD_CODE;
          end else if (font_q == FONT_GRAY_GB) begin
            res_o.kind         = KIND_HANZI_GRAY;
            res_o.glyph_offset = offset;
            res_o.invert       = inv;
          end else begin
            res_o.kind         = KIND_HANZI_MONO;
            res_o.glyph_offset = offset;
            res_o.out_fg       = fg_q;
            res_o.out_bg       = bg_q;
          end
        end
      end
    end else if (b == CHAR_NUL) begin
      stopped_d   = 1'b1;
      lead_pend_d = 1'b0;
      res_valid_o = 1'b1;
      res_o.kind  = KIND_FINISHED;
    end else begin
      cursor_x_d = x1;
      cursor_y_d = y1;
      if (y1 >= SCREEN_HEIGHT) begin
        stopped_d   = 1'b1;
        lead_pend_d = 1'b0;
        res_valid_o = 1'b1;
        res_o.kind  = KIND_FINISHED;
      end else if (b == CHAR_CR || b == CHAR_LF) begin
        cursor_x_d = '0;
        cursor_y_d = y1 + LINE_PITCH;
        drop_d     = 1'b1;
      end else if (!b[7]) begin
        cursor_x_d = x2 + GLYPH_NARROW;
        cursor_y_d = y2;
        if (font_q == FONT_GRAY_GB) begin
          res_valid_o      = 1'b1;
          res_o.kind       = KIND_ASCII_GRAY;
          res_o.draw_x     = x2;
          res_o.draw_y     = y2;
          res_o.ascii_code = b[6:0];
          res_o.invert     = inv;
        end else if (font_q != FONT_GRAY_OTHER) begin
          res_valid_o      = 1'b1;
          res_o.kind       = KIND_ASCII_MONO;
          res_o.draw_x     = x2;
          res_o.draw_y     = y2 + MONO_ASCII_DY;
          res_o.ascii_code = b[6:0];
          res_o.out_fg     = fg_q;
          res_o.out_bg     = bg_q;
        end
      end else begin
        if (wrap_lead) begin
          cursor_x_d = '0;
          cursor_y_d = y1 + LINE_PITCH;
        end
        lead_d      = b;
        lead_pend_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      font_q      <= FONT_GRAY_GB;
      cursor_x_q  <= '0;
      cursor_y_q  <= '0;
      lead_q      <= '0;
      lead_pend_q <= 1'b0;
      drop_q      <= 1'b0;
      stopped_q   <= 1'b1;
      fg_q        <= '0;
      bg_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        font_q <= font_kind_e'(cfg_wdata_i);
      end
      if (step_i) begin
        cursor_x_q  <= cursor_x_d;
        cursor_y_q  <= cursor_y_d;
        lead_q      <= lead_d;
        lead_pend_q <= lead_pend_d;
        drop_q      <= drop_d;
        stopped_q   <= stopped_d;
        fg_q        <= fg_d;
        bg_q        <= bg_d;
      end
    end
  end

`ifndef SYNTH
  a_finish_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && res_o.kind == KIND_FINISHED |=> stopped_q && !lead_pend_q)
    else $error("finished beat did not stop the layout");

  a_stopped_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q && item_i.cmd == CMD_BYTE |-> !res_valid_o)
    else $error("result produced while stopped");

  a_bad_code_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == KIND_BAD_CODE |-> res_o.glyph_offset == '0 && !res_o.invert)
    else $error("bad code beat carries an offset");

  a_begin_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.cmd == CMD_BEGIN |=> !stopped_q && !lead_pend_q && !drop_q)
    else $error("begin did not clear pending state");
`endif

endmodule

`default_nettype wire

// ===== sim/dtl_layout_checker.sv =====
// Scoreboard for the text layout / glyph address block: a cycle-free layout
// predictor fed from the input channel, checked against the output channel.
// Depends on dtl_pkg, dtl_in_if and dtl_out_if.
`timescale 1ns / 1ps

module dtl_layout_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  dtl_in_if           in_ch,
  dtl_out_if          out_ch,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned in_beats_o,
  output int unsigned cmds_o,
  output int unsigned hanzi_cmds_o,
  output int unsigned bad_cmds_o,
  output int unsigned done_cmds_o
);
  import dtl_pkg::*;

  localparam int GB_GRAY_BASE     = 'hA0;
  localparam int GB_MONO_BASE     = 'hA1;
  localparam int GBK_LEAD_BASE    = 'h81;
  localparam int GBK_TRAIL_LO     = 'h40;
  localparam int GBK_TRAIL_HI     = 'h41;
  localparam int GBK_TRAIL_SPLIT  = 'h7F;
  localparam int GB_ROW_CODES     = 94;
  localparam int GBK_ROW_CODES    = 190;
  localparam int GRAY_GLYPH_BYTES = 128;
  localparam int MONO_GLYPH_BYTES = 32;
  localparam int REPORT_MAX       = 10;

  // predicted layout state
  font_kind_e font_sel;
  logic [9:0] pen_x, pen_y;
  logic [7:0] lead_code;
  logic       lead_held, skip_next, halted;
  logic [3:0] text_fg, text_bg;

  out_beat_t  draw_q [$];

  task automatic next_line();
    pen_x = '0;
    pen_y = pen_y + LINE_PITCH;
  endtask

  task automatic end_text(output out_beat_t c);
    halted    = 1'b1;
    lead_held = 1'b0;
    c         = '0;
    c.kind    = KIND_FINISHED;
  endtask

  // one accepted beat -> zero or one draw command
  task automatic layout_step(input in_beat_t b);
    out_beat_t  c;
    logic       has_cmd;
    logic       inv;
    logic [9:0] px, py;
    int         lead_i, trail_i, offs;
    c       = '0;
    has_cmd = 1'b0;
    inv     = (text_fg == 4'hF) && (text_bg == 4'h0);
    lead_i  = int'(lead_code);
    trail_i = int'(b.code_byte);
    if (b.cmd == CMD_BEGIN) begin
      pen_x     = {1'b0, b.start_x};
      pen_y     = {1'b0, b.start_y};
      text_fg   = b.fg_color;
      text_bg   = b.bg_color;
      halted    = 1'b0;
      lead_held = 1'b0;
      lead_code = '0;
      skip_next = 1'b0;
    end else if (halted) begin
      // ignored until the next begin
    end else if (skip_next) begin
      skip_next = 1'b0;
    end else if (lead_held) begin
      if (b.code_byte == CHAR_NUL) begin
        end_text(c);
        has_cmd = 1'b1;
      end else begin
        lead_held = 1'b0;
        px        = pen_x;
        py        = pen_y;
        pen_x     = pen_x + GLYPH_WIDE;
        if (!(lead_code == CHAR_WIDE_SP && b.code_byte == CHAR_WIDE_SP) &&
            font_sel != FONT_GRAY_OTHER) begin
          case (font_sel)
            FONT_GRAY_GB: offs = (GB_ROW_CODES * (lead_i - GB_GRAY_BASE) +
                                  (trail_i - GB_GRAY_BASE)) * GRAY_GLYPH_BYTES;
            FONT_MONO_GB: offs = (GB_ROW_CODES * (lead_i - GB_MONO_BASE) +
                                  (trail_i - GB_MONO_BASE)) * MONO_GLYPH_BYTES;
            default:      offs = (GBK_ROW_CODES * (lead_i - GBK_LEAD_BASE) +
                                  (trail_i - ((trail_i < GBK_TRAIL_SPLIT) ?
                                   GBK_TRAIL_LO : GBK_TRAIL_HI))) * MONO_GLYPH_BYTES;
          endcase
          has_cmd  = 1'b1;
          c.draw_x = px;
          c.draw_y = py;
          if (offs < 0) begin
            c.kind = KIND_BAD_CODE;
          end else if (font_sel == FONT_GRAY_GB) begin
            c.kind         = KIND_HANZI_GRAY;
            c.glyph_offset = offs[20:0];
            c.invert       = inv;
          end else begin
            c.kind         = KIND_HANZI_MONO;
            c.glyph_offset = offs[20:0];
            c.out_fg       = text_fg;
            c.out_bg       = text_bg;
          end
        end
      end
    end else if (b.code_byte == CHAR_NUL) begin
      end_text(c);
      has_cmd = 1'b1;
    end else begin
      if (pen_x > SCREEN_WIDTH) next_line();
      if (pen_y >= SCREEN_HEIGHT) begin
        end_text(c);
        has_cmd = 1'b1;
      end else if (b.code_byte < 8'h80) begin
        if (b.code_byte == CHAR_CR || b.code_byte == CHAR_LF) begin
          next_line();
          skip_next = 1'b1;
        end else begin
          if (pen_x > SCREEN_WIDTH - GLYPH_NARROW) next_line();
          px    = pen_x;
          py    = pen_y;
          pen_x = pen_x + GLYPH_NARROW;
          if (font_sel == FONT_GRAY_GB) begin
            has_cmd      = 1'b1;
            c.kind       = KIND_ASCII_GRAY;
            c.draw_x     = px;
            c.draw_y     = py;
            c.ascii_code = b.code_byte[6:0];
            c.invert     = inv;
          end else if (font_sel != FONT_GRAY_OTHER) begin
            has_cmd      = 1'b1;
            c.kind       = KIND_ASCII_MONO;
            c.draw_x     = px;
            c.draw_y     = py + MONO_ASCII_DY;
            c.ascii_code = b.code_byte[6:0];
            c.out_fg     = text_fg;
            c.out_bg     = text_bg;
          end
        end
      end else begin
        if (int'(pen_x) + int'(GLYPH_NARROW) >= int'(SCREEN_WIDTH)) next_line();
        lead_code = b.code_byte;
        lead_held = 1'b1;
      end
    end
    if (has_cmd) draw_q.push_back(c);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_beat_t got, want;
    string     diffs;
    if (!rst_ni) begin
      font_sel  = FONT_GRAY_GB;
      pen_x     = '0;
      pen_y     = '0;
      lead_code = '0;
      lead_held = 1'b0;
      skip_next = 1'b0;
      halted    = 1'b1;
      text_fg   = '0;
      text_bg   = '0;
      draw_q.delete();
      fail_cnt_o   = 0;
      pending_o    = 0;
      in_beats_o   = 0;
      cmds_o       = 0;
      hanzi_cmds_o = 0;
      bad_cmds_o   = 0;
      done_cmds_o  = 0;
    end else begin
      if (cfg_we_i) font_sel = font_kind_e'(cfg_wdata_i);

      // compare first: a command never belongs to a beat taken at this edge
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        cmds_o++;
        case (got.kind)
          KIND_HANZI_GRAY, KIND_HANZI_MONO: hanzi_cmds_o++;
          KIND_BAD_CODE:                    bad_cmds_o++;
          KIND_FINISHED:                    done_cmds_o++;
          default: ;
        endcase
        if (draw_q.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= REPORT_MAX)
            $display("%0t checker: unexpected command kind %0d x %0d y %0d",
                     $realtime, got.kind, got.draw_x, got.draw_y);
        end else begin
          want = draw_q.pop_front();
          if (got !== want) begin
            fail_cnt_o++;
            diffs = "";
            if (got.kind !== want.kind)                 diffs = {diffs, " kind"};
            if (got.draw_x !== want.draw_x)             diffs = {diffs, " draw_x"};
            if (got.draw_y !== want.draw_y)             diffs = {diffs, " draw_y"};
            if (got.ascii_code !== want.ascii_code)     diffs = {diffs, " ascii_code"};
            if (got.glyph_offset !== want.glyph_offset) diffs = {diffs, " glyph_offset"};
            if (got.invert !== want.invert)             diffs = {diffs, " invert"};
            if (got.out_fg !== want.out_fg)             diffs = {diffs, " out_fg"};
            if (got.out_bg !== want.out_bg)             diffs = {diffs, " out_bg"};
            if (fail_cnt_o <= REPORT_MAX) begin
              $display("%0t checker: command mismatch in%s", $realtime, diffs);
              $display("  expected kind %0d x %0d y %0d chr %h off %h inv %b fg %h bg %h",
                       want.kind, want.draw_x, want.draw_y, want.ascii_code,
                       want.glyph_offset, want.invert, want.out_fg, want.out_bg);
              $display("  actual   kind %0d x %0d y %0d chr %h off %h inv %b fg %h bg %h",
                       got.kind, got.draw_x, got.draw_y, got.ascii_code,
                       got.glyph_offset, got.invert, got.out_fg, got.out_bg);
            end
          end
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        in_beats_o++;
        layout_step(in_ch.payload);
      end
      pending_o = draw_q.size();
    end
  end

endmodule

// ===== sim/tb_dbcs_text_layout_glyph_address.sv =====
// Top-level bench for dbcs_text_layout_glyph_address: clock, reset, string
// stimulus with random idling, font switching, and the final verdict.
// Depends on dtl_pkg, dtl_in_if, dtl_out_if, the block, dtl_layout_checker.
`timescale 1ns / 1ps

module tb_dbcs_text_layout_glyph_address;
  import dtl_pkg::*;

  localparam int HALF_PERIOD  = 4;     // 8 ns clock
  localparam int RESET_CYCLES = 11;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 185;   // ~1500 random beats over all phases
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int SETTLE_WAIT  = 4;     // waits out the input and output registers, with margin
  localparam int IDLE_LIMIT   = 3000;  // cycles without any beat before giving up

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_wdata_i;

  dtl_in_if  in_ch ();
  dtl_out_if out_ch ();

  int unsigned fail_cnt, pending, in_beats, cmds, hanzi_cmds, bad_cmds, done_cmds;

  // Stimulus-side state shared between the sender, the receiver and the
  // main sequence.
  font_kind_e cur_font;      // font the block is set to right now
  font_kind_e plan [0:PHASES-1];
  int         text_items;    // beats counted toward the phase quota
  logic       tx_gappy;      // sender inserts idle gaps when set
  int         hold_ticket;   // bumped to ask the receiver for a long hold-off

  dbcs_text_layout_glyph_address u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  dtl_layout_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending),
    .in_beats_o   (in_beats),
    .cmds_o       (cmds),
    .hanzi_cmds_o (hanzi_cmds),
    .bad_cmds_o   (bad_cmds),
    .done_cmds_o  (done_cmds)
  );

  initial clk_i = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Sender. Every call starts and ends at a falling edge. Valid is left high
  // after an accepted beat so back-to-back beats never see valid toggled
  // within one time step; a gap lowers it once, then raises it later.
  // ---------------------------------------------------------------------------
  task automatic put_beat(input in_beat_t b);
    int r, gap;
    gap = 0;
    if (tx_gappy) begin
      r = $urandom_range(0, 99);
      if (r >= 92)      gap = $urandom_range(6, 30);   // rare long gap
      else if (r >= 45) gap = $urandom_range(1, 3);    // common short gap
    end
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid   = 1'b1;
    in_ch.payload = b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Start fields are don't-care on byte beats; randomize them for bit toggling.
  task automatic put_byte(input logic [7:0] c);
    in_beat_t b;
    b.cmd       = CMD_BYTE;
    b.code_byte = c;
    b.start_x   = 9'($urandom_range(0, 511));
    b.start_y   = 9'($urandom_range(0, 511));
    b.fg_color  = 4'($urandom_range(0, 15));
    b.bg_color  = 4'($urandom_range(0, 15));
    text_items++;
    put_beat(b);
  endtask

  task automatic begin_text(input int x, input int y, input int fgc, input int bgc);
    in_beat_t b;
    b.cmd       = CMD_BEGIN;
    b.code_byte = 8'($urandom_range(0, 255));   // ignored on begin
    b.start_x   = 9'(x);
    b.start_y   = 9'(y);
    b.fg_color  = 4'(fgc);
    b.bg_color  = 4'(bgc);
    text_items++;
    put_beat(b);
  endtask

  // Quiesce: drop valid, let every expected command drain, give the block its
  // pipeline latency to finish beats that make no command, then write the font.
  task automatic settle_and_set_font(input font_kind_e f);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_WAIT) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = f;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cur_font    = f;
  endtask

  // Random begin: mostly placements that leave room for a few lines of text,
  // sometimes anywhere in the 9-bit range (including off-screen).
  task automatic random_begin();
    int x, y, fgc, bgc;
    x   = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 320) : $urandom_range(0, 511);
    y   = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 200) : $urandom_range(0, 511);
    fgc = $urandom_range(0, 15);
    bgc = $urandom_range(0, 15);
    if ($urandom_range(0, 4) == 0) begin
      fgc = 15;        // the inverted-gray color pair
      bgc = 0;
    end
    begin_text(x, y, fgc, bgc);
  endtask

  // One well-formed-ish string: begin, a mix of characters, usually a NUL.
  task automatic send_random_text(input int n);
    int         k, r;
    logic [7:0] c1, c2;
    tx_gappy = ($urandom_range(0, 9) < 7);
    random_begin();
    k = 0;
    while (k < n) begin
      r = $urandom_range(0, 99);
      if (r < 38) begin
        put_byte(8'($urandom_range(32, 126)));
        k++;
      end else if (r < 42) begin
        // the byte after a line break is swallowed, whatever it is
        put_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
        k++;
      end else if (r < 78) begin
        if ($urandom_range(0, 3) == 0) begin
          // arbitrary pair: exercises negative offsets as well
          c1 = 8'($urandom_range(128, 255));
          c2 = 8'($urandom_range(1, 255));
        end else if (cur_font == FONT_MONO_GBK) begin
          c1 = 8'($urandom_range('h81, 'hFE));
          c2 = 8'($urandom_range('h40, 'hFE));
        end else begin
          c1 = 8'($urandom_range('hA1, 'hF7));
          c2 = 8'($urandom_range('hA1, 'hFE));
        end
        put_byte(c1);
        put_byte(c2);
        k += 2;
      end else if (r < 83) begin
        put_byte(CHAR_WIDE_SP);
        put_byte(CHAR_WIDE_SP);
        k += 2;
      end else if (r < 89) begin
        put_byte(8'($urandom_range(0, 255)));   // may end the string early
        k++;
      end else if (r < 91) begin
        random_begin();                         // restart mid-string
        k++;
      end else begin
        put_byte(8'($urandom_range(1, 127)));
        k++;
      end
    end
    if ($urandom_range(0, 4) != 0) put_byte(CHAR_NUL);
    // occasional trailing junk, normally swallowed by the stopped block
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        put_byte(8'($urandom_range(0, 255)));
        text_items--;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver. Ready is set once per falling edge. Random stalls come and go in
  // stretches; a bumped hold_ticket forces one long hold-off counted here.
  // ---------------------------------------------------------------------------
  initial begin
    int   stall, served, r, stretch;
    logic rx_gappy;
    out_ch.ready = 1'b0;
    stall    = 0;
    served   = 0;
    stretch  = 0;
    rx_gappy = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stretch <= 0) begin
        rx_gappy = ($urandom_range(0, 3) != 0);
        stretch  = $urandom_range(50, 200);
      end
      stretch--;
      if (hold_ticket != served) begin
        served       = hold_ticket;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else if (stall > 0) begin
        stall--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
        if (rx_gappy) begin
          r = $urandom_range(0, 99);
          if (r < 20)      stall = $urandom_range(1, 3);
          else if (r < 23) stall = $urandom_range(8, 40);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: a run whose idle count reaches IDLE_LIMIT, with no beat moved on
  // either channel, is hung. The limit covers the long hold-off plus the worst sender gap.
  // ---------------------------------------------------------------------------
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("watchdog: no beat moved for %0d cycles, %0d commands outstanding",
             IDLE_LIMIT, pending);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int ph, i;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = FONT_GRAY_GB;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    cur_font      = FONT_GRAY_GB;
    tx_gappy      = 1'b0;
    hold_ticket   = 0;
    text_items    = 0;
    plan = '{FONT_MONO_GB, FONT_GRAY_OTHER, FONT_MONO_GBK, FONT_GRAY_GB,
             FONT_MONO_GBK, FONT_GRAY_OTHER, FONT_MONO_GB, FONT_GRAY_GB};
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed pass at the reset font (gray GB2312), gaps on.
    tx_gappy = 1'b1;
    put_byte(8'h41);                         // stopped after reset: ignored
    begin_text(0, 0, 15, 0);                 // inverted color pair
    put_byte(8'h41);
    put_byte(8'h7F);                         // top of the single-byte range
    put_byte(CHAR_CR);
    put_byte(CHAR_NUL);                      // swallowed after CR, no finish
    put_byte(CHAR_LF);
    put_byte(8'h42);                         // swallowed after LF
    put_byte(8'hB0);
    put_byte(8'hA1);
    put_byte(CHAR_WIDE_SP);                  // full-width space: advance only
    put_byte(CHAR_WIDE_SP);
    put_byte(8'h81);
    put_byte(8'h40);                         // below the table: bad code
    put_byte(8'hFF);
    put_byte(8'hFF);                         // largest offset
    put_byte(8'hC0);
    put_byte(CHAR_NUL);                      // NUL as trail byte: finish
    put_byte(8'h55);                         // ignored while stopped
    begin_text(511, 0, 3, 9);
    put_byte(8'h31);                         // cursor past the right edge
    begin_text(316, 0, 0, 15);
    put_byte(8'h32);                         // narrow glyph wraps
    begin_text(310, 511, 15, 0);
    begin_text(310, 0, 15, 0);               // begin over begin
    put_byte(8'hB1);                         // lead byte at x 310 does not wrap
    put_byte(8'hB2);
    begin_text(0, 511, 7, 7);
    put_byte(8'h33);                         // below the bottom: finish
    begin_text(0, 0, 0, 0);
    put_byte(8'h80);
    put_byte(8'h01);                         // lead below the table: bad code
    put_byte(CHAR_NUL);

    // Random phases, one font each; every font value visited twice.
    for (ph = 0; ph < PHASES; ph++) begin
      settle_and_set_font(plan[ph]);         // sender stays idle until drained
      text_items = 0;
      if (ph == 0 || ph == 4) begin
        // Long receiver hold-off while a dense, gapless string keeps
        // arriving, so the block fills and backpressures its input.
        tx_gappy = 1'b0;
        begin_text(0, 0, $urandom_range(0, 15), $urandom_range(0, 15));
        hold_ticket++;
        for (i = 0; i < 40; i++) put_byte(8'($urandom_range(32, 126)));
        put_byte(CHAR_NUL);
      end
      while (text_items < PHASE_ITEMS) send_random_text($urandom_range(2, 40));
    end

    // Drain, then allow for trailing beats that make no command.
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (2 * SETTLE_WAIT) @(negedge clk_i);

    $display("Covered %0d input beats and %0d draw commands across all four fonts:",
             in_beats, cmds);
    $display("  %0d hanzi, %0d bad code, %0d finished, with long output hold-offs.",
             hanzi_cmds, bad_cmds, done_cmds);
    if (fail_cnt == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures", fail_cnt);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
